@@ hw/rtl/tps_pkg.sv @@
// Shared types, widths and codes for the triangle plane splitter.
`default_nettype none

package tps_pkg;

  localparam int COORD_W = 32;
  localparam int NRM_W   = 16;
  localparam int PROD_W  = NRM_W + COORD_W;
  localparam int DIST_W  = PROD_W + 2;
  localparam int MAG_W   = DIST_W + 1;
  localparam int REM_W   = MAG_W + 1;
  localparam int T_W     = 32;
  localparam int T_FRAC  = 31;
  localparam int CNT_W   = $clog2(T_W);
  localparam int DIFF_W  = COORD_W + 1;
  localparam int LPROD_W = 2 * DIFF_W;
  localparam int SUM_W   = COORD_W + 4;
  localparam int OFFS_SH = 14;
  localparam int QDEPTH  = 2;

  localparam logic [1:0] KIND_FRONT     = 2'd0;
  localparam logic [1:0] KIND_BACK      = 2'd1;
  localparam logic [1:0] KIND_FRONT_CAP = 2'd2;
  localparam logic [1:0] KIND_BACK_CAP  = 2'd3;

  // Axis 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][COORD_W-1:0] vec_t;

  typedef struct packed {
    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
    logic signed [COORD_W-1:0] offs;
  } plane_t;

  typedef struct packed {
    logic             split;
    logic             iso_front;
    vec_t             p0;
    vec_t             p1;
    vec_t             p2;
    logic [MAG_W-1:0] num1;
    logic [MAG_W-1:0] den1;
    logic [MAG_W-1:0] num2;
    logic [MAG_W-1:0] den2;
  } job_t;

  typedef struct packed {
    logic [1:0] kind;
    vec_t       v0;
    vec_t       v1;
    vec_t       v2;
    logic       last;
  } res_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/triangle_plane_splitter.sv @@
// Top level of the triangle plane splitter: register port, front, queue and back.
//
//  Channel   | Handshake          | Payload
//  ----------+--------------------+-----------------------------------------
//  triangle  | push / full        | a_*_i, b_*_i, c_*_i (Q16.16 vertices)
//  result    | pop / empty        | kind_o, r0_*_o .. r2_*_o, last_o
//  registers | psel/penable/pready| paddr, pwdata, prdata (plane, 4 words)
//
// A triangle passes through the front's product and distance registers (the
// side test works on the distances) before it lands in a two-entry job queue.
// The back takes a triangle wholly on one side straight from the job to its
// single result. A split triangle in the back goes through taking the job,
// bit-serial division with 32 quotient bits for the two crossing ratios, a
// multiply, an add-and-saturate step, then four result transactions.
// The front keeps accepting triangles while the back works, until the queue
// fills; results wait in a two-entry output buffer. Reset is asynchronous
// and active low and restores the plane to normal (0, 1, 0), offset 0.
`default_nettype none

module triangle_plane_splitter import tps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] a_x_i,
  input  wire logic [31:0] a_y_i,
  input  wire logic [31:0] a_z_i,
  input  wire logic [31:0] b_x_i,
  input  wire logic [31:0] b_y_i,
  input  wire logic [31:0] b_z_i,
  input  wire logic [31:0] c_x_i,
  input  wire logic [31:0] c_y_i,
  input  wire logic [31:0] c_z_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [31:0]      r0_x_o,
  output logic [31:0]      r0_y_o,
  output logic [31:0]      r0_z_o,
  output logic [31:0]      r1_x_o,
  output logic [31:0]      r1_y_o,
  output logic [31:0]      r1_z_o,
  output logic [31:0]      r2_x_o,
  output logic [31:0]      r2_y_o,
  output logic [31:0]      r2_z_o,
  output logic             last_o
);

  localparam logic [1:0] REG_NX   = 2'd0;
  localparam logic [1:0] REG_NY   = 2'd1;
  localparam logic [1:0] REG_NZ   = 2'd2;
  localparam logic [1:0] REG_OFFS = 2'd3;

  plane_t     plane_q;
  logic       cfg_wr, in_accept, stall, q_push, q_full, q_pop, q_empty;
  logic [1:0] reg_idx;
  vec_t       vert [3];
  job_t       job_in, job_out;
  res_t       res;

  // Register port: every transaction completes in its access cycle.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.nx   <= '0;
      plane_q.ny   <= NRM_W'(16384);
      plane_q.nz   <= '0;
      plane_q.offs <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NX:   plane_q.nx   <= pwdata[NRM_W-1:0];
        REG_NY:   plane_q.ny   <= pwdata[NRM_W-1:0];
        REG_NZ:   plane_q.nz   <= pwdata[NRM_W-1:0];
        REG_OFFS: plane_q.offs <= pwdata;
      endcase
    end
  end

  // Reads return the registers sign-extended to the data width.
  always_comb begin
    unique case (reg_idx)
      REG_NX:   prdata = 32'(plane_q.nx);
      REG_NY:   prdata = 32'(plane_q.ny);
      REG_NZ:   prdata = 32'(plane_q.nz);
      REG_OFFS: prdata = plane_q.offs;
    endcase
  end

  // A triangle transaction completes whenever the front is not stalled.
  assign full      = stall;
  assign in_accept = push && !full;

  assign vert[0] = {a_z_i, a_y_i, a_x_i};
  assign vert[1] = {b_z_i, b_y_i, b_x_i};
  assign vert[2] = {c_z_i, c_y_i, c_x_i};

  tps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .plane_i    (plane_q),
    .accept_i   (in_accept),
    .vert_i     (vert),
    .stall_o    (stall),
    .job_push_o (q_push),
    .job_o      (job_in),
    .job_full_i (q_full)
  );

  tps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  tps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (q_empty),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign kind_o = res.kind;
  assign r0_x_o = res.v0[0];
  assign r0_y_o = res.v0[1];
  assign r0_z_o = res.v0[2];
  assign r1_x_o = res.v1[0];
  assign r1_y_o = res.v1[1];
  assign r1_z_o = res.v1[2];
  assign r2_x_o = res.v2[0];
  assign r2_y_o = res.v2[1];
  assign r2_z_o = res.v2[2];
  assign last_o = res.last;

endmodule

`default_nettype wire

@@ hw/rtl/tps_queue.sv @@
// Two-entry job queue between the classifier and the split engine.
`default_nettype none

module tps_queue import tps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tps_front.sv @@
// Front end: vertex distances, side test and isolated-vertex selection.
`default_nettype none

module tps_front import tps_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire plane_t plane_i,
  input  wire logic   accept_i,
  input  wire vec_t   vert_i [3],
  output logic        stall_o,
  output logic        job_push_o,
  output job_t        job_o,
  input  wire logic   job_full_i
);

  logic                     va_q, vb_q, adv;
  logic signed [PROD_W-1:0] prod_q [3][3];
  vec_t                     verta_q [3];
  vec_t                     vertb_q [3];
  logic signed [DIST_W-1:0] dist_q [3];
  logic [NRM_W-1:0]         nrm [3];
  logic [2:0]               fr;
  logic [1:0]               iso;
  logic signed [DIST_W-1:0] d0, d1, d2;
  logic signed [MAG_W-1:0]  diff1, diff2;

  // The whole front moves together; it holds while a finished job waits on a full queue.
  assign adv     = !(vb_q && job_full_i);
  assign stall_o = !adv;
  assign job_push_o = vb_q;

  assign nrm[0] = plane_i.nx;
  assign nrm[1] = plane_i.ny;
  assign nrm[2] = plane_i.nz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv) begin
      va_q <= accept_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        verta_q[i] <= vert_i[i];
        vertb_q[i] <= verta_q[i];
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= PROD_W'($signed(nrm[j])) * PROD_W'($signed(vert_i[i][j]));
        end
        dist_q[i] <= DIST_W'(prod_q[i][0]) + DIST_W'(prod_q[i][1]) + DIST_W'(prod_q[i][2])
                   + (DIST_W'(plane_i.offs) <<< OFFS_SH);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) fr[i] = ~dist_q[i][DIST_W-1];
    if (fr[0] == fr[1] && fr[1] == fr[2]) iso = 2'd0;
    else if (fr[0] == fr[2])              iso = 2'd1;
    else if (fr[1] == fr[2])              iso = 2'd0;
    else                                  iso = 2'd2;

    job_o.split = !(fr[0] == fr[1] && fr[1] == fr[2]);
    unique case (iso)
      2'd1: begin
        job_o.p0 = vertb_q[1]; job_o.p1 = vertb_q[2]; job_o.p2 = vertb_q[0];
        d0 = dist_q[1]; d1 = dist_q[2]; d2 = dist_q[0];
        job_o.iso_front = fr[1];
      end
      2'd2: begin
        job_o.p0 = vertb_q[2]; job_o.p1 = vertb_q[0]; job_o.p2 = vertb_q[1];
        d0 = dist_q[2]; d1 = dist_q[0]; d2 = dist_q[1];
        job_o.iso_front = fr[2];
      end
      default: begin
        job_o.p0 = vertb_q[0]; job_o.p1 = vertb_q[1]; job_o.p2 = vertb_q[2];
        d0 = dist_q[0]; d1 = dist_q[1]; d2 = dist_q[2];
        job_o.iso_front = fr[0];
      end
    endcase

    diff1 = MAG_W'(d0) - MAG_W'(d1);
    diff2 = MAG_W'(d0) - MAG_W'(d2);
    job_o.num1 = mag(MAG_W'(d0));
    job_o.num2 = mag(MAG_W'(d0));
    job_o.den1 = mag(diff1);
    job_o.den2 = mag(diff2);
  end

endmodule

`default_nettype wire

@@ hw/rtl/tps_back.sv @@
// Back end: crossing ratios, edge interpolation and result sequencing.
`default_nettype none

module tps_back import tps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_empty_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  output res_t      res_o,
  output logic      empty_o,
  input  wire logic pop_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                state_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [1:0]                idx_q;
  job_t                      job_q;
  logic [REM_W-1:0]          r1_q, r2_q, r1_cur, r2_cur;
  logic [T_W-1:0]            q1_q, q2_q, t1, t2;
  logic                      ge1, ge2;
  logic signed [LPROD_W-1:0] lprod_q [2][3];
  vec_t                      s1_q, s2_q, s_new [2];
  logic signed [SUM_W-1:0]   sum;
  res_t                      res;
  logic                      last_res, emit;

  res_t                      ob_q [2];
  logic                      ob_wr_q, ob_rd_q;
  logic [1:0]                ob_cnt_q;
  logic                      ob_full, ob_pop;

  assign ob_full  = (ob_cnt_q == 2'd2);
  assign empty_o  = (ob_cnt_q == 2'd0);
  assign ob_pop   = pop_i && !empty_o;
  assign res_o    = ob_q[ob_rd_q];
  assign emit     = (state_q == ST_EMIT) && !ob_full;
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;

  // Restoring division, one quotient bit per cycle; the first step has no shift.
  always_comb begin
    r1_cur = (cnt_q == '0) ? r1_q : (r1_q << 1);
    r2_cur = (cnt_q == '0) ? r2_q : (r2_q << 1);
    ge1 = (r1_cur >= REM_W'(job_q.den1));
    ge2 = (r2_cur >= REM_W'(job_q.den2));
    t1  = (job_q.den1 == '0) ? '0 : q1_q;
    t2  = (job_q.den2 == '0) ? '0 : q2_q;
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        sum = SUM_W'($signed(job_q.p0[j])) + SUM_W'(lprod_q[k][j] >>> T_FRAC);
        if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1)
          s_new[k][j] = sum[COORD_W-1:0];
        else if (sum[SUM_W-1])
          s_new[k][j] = {1'b1, {(COORD_W-1){1'b0}}};
        else
          s_new[k][j] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    last_res = !job_q.split || (idx_q == 2'd3);
    res.last = last_res;
    res.v2   = '0;
    if (!job_q.split) begin
      res.kind = job_q.iso_front ? KIND_FRONT : KIND_BACK;
      res.v0 = job_q.p0; res.v1 = job_q.p1; res.v2 = job_q.p2;
    end else begin
      unique case (idx_q)
        2'd0: begin
          res.kind = job_q.iso_front ? KIND_FRONT_CAP : KIND_BACK_CAP;
          res.v0 = s1_q; res.v1 = s2_q;
        end
        2'd1: begin
          res.kind = job_q.iso_front ? KIND_FRONT : KIND_BACK;
          res.v0 = job_q.p0; res.v1 = s1_q; res.v2 = s2_q;
        end
        2'd2: begin
          res.kind = job_q.iso_front ? KIND_BACK : KIND_FRONT;
          res.v0 = job_q.p1; res.v1 = job_q.p2; res.v2 = s2_q;
        end
        default: begin
          res.kind = job_q.iso_front ? KIND_BACK : KIND_FRONT;
          res.v0 = job_q.p1; res.v1 = s2_q; res.v2 = s1_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (!job_empty_i) begin
          cnt_q   <= '0;
          idx_q   <= '0;
          state_q <= job_i.split ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(T_W - 1)) state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: state_q <= ST_EMIT;
        ST_EMIT: if (emit) begin
          idx_q <= idx_q + 1'b1;
          if (last_res) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      r1_q  <= REM_W'(job_i.num1);
      r2_q  <= REM_W'(job_i.num2);
      q1_q  <= '0;
      q2_q  <= '0;
    end
    if (state_q == ST_DIV) begin
      r1_q <= ge1 ? r1_cur - REM_W'(job_q.den1) : r1_cur;
      r2_q <= ge2 ? r2_cur - REM_W'(job_q.den2) : r2_cur;
      q1_q <= {q1_q[T_W-2:0], ge1};
      q2_q <= {q2_q[T_W-2:0], ge2};
    end
    if (state_q == ST_MUL) begin
      for (int j = 0; j < 3; j++) begin
        lprod_q[0][j] <= LPROD_W'(DIFF_W'($signed(job_q.p1[j])) - DIFF_W'($signed(job_q.p0[j])))
                       * LPROD_W'($signed({1'b0, t1}));
        lprod_q[1][j] <= LPROD_W'(DIFF_W'($signed(job_q.p2[j])) - DIFF_W'($signed(job_q.p0[j])))
                       * LPROD_W'($signed({1'b0, t2}));
      end
    end
    if (state_q == ST_ADD) begin
      s1_q <= s_new[0];
      s2_q <= s_new[1];
    end
    if (emit) ob_q[ob_wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      if (emit)   ob_wr_q <= ~ob_wr_q;
      if (ob_pop) ob_rd_q <= ~ob_rd_q;
      if (emit && !ob_pop)      ob_cnt_q <= ob_cnt_q + 1'b1;
      else if (ob_pop && !emit) ob_cnt_q <= ob_cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_triangle_plane_splitter.sv @@
// Self-checking testbench for the triangle plane splitter.
module tb_triangle_plane_splitter;
  import tps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
  } tri_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  vec_t        drv_a, drv_b, drv_c;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [31:0] r0_x_o, r0_y_o, r0_z_o, r1_x_o, r1_y_o, r1_z_o, r2_x_o, r2_y_o, r2_z_o;
  logic        last_o;

  triangle_plane_splitter uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full,
    .a_x_i(drv_a[0]), .a_y_i(drv_a[1]), .a_z_i(drv_a[2]),
    .b_x_i(drv_b[0]), .b_y_i(drv_b[1]), .b_z_i(drv_b[2]),
    .c_x_i(drv_c[0]), .c_y_i(drv_c[1]), .c_z_i(drv_c[2]),
    .empty, .pop, .kind_o,
    .r0_x_o, .r0_y_o, .r0_z_o, .r1_x_o, .r1_y_o, .r1_z_o,
    .r2_x_o, .r2_y_o, .r2_z_o, .last_o
  );

  // The plane as the testbench believes it is programmed.
  longint plane_nx, plane_ny, plane_nz, plane_offs;

  tri_t triangles_pending[$];
  res_t pieces_expected[$];
  int   error_count;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_request;
  bit   hold_done;
  int   hold_left;

  // Clock and the single reset at the start of the run.
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Exact plane distance of one vertex, Q.30.
  function automatic longint plane_distance(vec_t p);
    return plane_nx * longint'($signed(p[0])) + plane_ny * longint'($signed(p[1])) +
           plane_nz * longint'($signed(p[2])) + plane_offs * 16384;
  endfunction

  // Crossing point on the edge p0-pk, with t = d0/(d0-dk) in truncated Q1.31.
  function automatic vec_t crossing_point(vec_t p0, vec_t pk, longint d0, longint dk);
    logic [127:0]        num, den, t;
    logic signed [127:0] diff, prod;
    longint              base, s;
    vec_t                r;
    num = 128'(d0 < 0 ? -d0 : d0) << 31;
    den = 128'((d0 - dk) < 0 ? -(d0 - dk) : (d0 - dk));
    t   = num / den;
    for (int j = 0; j < 3; j++) begin
      base = longint'($signed(p0[j]));
      diff = longint'($signed(pk[j])) - base;
      prod = diff * $signed({1'b0, t[126:0]});
      // Arithmetic shift gives the floor, also for negative steps.
      s = base + longint'(prod >>> 31);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      r[j] = s[31:0];
    end
    return r;
  endfunction

  function automatic res_t make_piece(logic [1:0] kind, vec_t v0, vec_t v1, vec_t v2,
                                      logic last);
    res_t r;
    r.kind = kind;
    r.v0   = v0;
    r.v1   = v1;
    r.v2   = v2;
    r.last = last;
    return r;
  endfunction

  // Appends one piece to the tail of the expected list.
  task automatic expect_piece(res_t p);
    pieces_expected.insert(pieces_expected.size(), p);
  endtask

  // Works out every piece that one triangle yields and queues them in order.
  task automatic split_triangle(tri_t t);
    vec_t   v[3];
    vec_t   s1, s2, zero;
    longint d[3];
    bit     fr[3];
    int     iso, n1, n2;
    logic [1:0] iso_kind, maj_kind;
    v[0] = t.a;
    v[1] = t.b;
    v[2] = t.c;
    zero = '0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = plane_distance(v[i]);
      fr[i] = d[i] >= 0;
    end
    if (fr[0] == fr[1] && fr[1] == fr[2]) begin
      expect_piece(make_piece(fr[0] ? KIND_FRONT : KIND_BACK, v[0], v[1], v[2], 1'b1));
    end else begin
      if (fr[0] == fr[2]) iso = 1;
      else if (fr[1] == fr[2]) iso = 0;
      else iso = 2;
      n1 = (iso + 1) % 3;
      n2 = (iso + 2) % 3;
      s1 = crossing_point(v[iso], v[n1], d[iso], d[n1]);
      s2 = crossing_point(v[iso], v[n2], d[iso], d[n2]);
      iso_kind = fr[iso] ? KIND_FRONT : KIND_BACK;
      maj_kind = fr[iso] ? KIND_BACK : KIND_FRONT;
      expect_piece(make_piece(fr[iso] ? KIND_FRONT_CAP : KIND_BACK_CAP,
                              s1, s2, zero, 1'b0));
      expect_piece(make_piece(iso_kind, v[iso], s1, s2, 1'b0));
      expect_piece(make_piece(maj_kind, v[n1], v[n2], s2, 1'b0));
      expect_piece(make_piece(maj_kind, v[n1], s2, s1, 1'b1));
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Driver: an accepted transaction is predicted, then the next one is offered.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        split_triangle(triangles_pending.pop_front());
      end
      if (triangles_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push  <= 1'b1;
        drv_a <= triangles_pending[0].a;
        drv_b <= triangles_pending[0].b;
        drv_c <= triangles_pending[0].c;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so that the block fills and stalls input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: each accepted result transaction is checked against the oldest piece.
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pieces_expected.size() == 0) begin
          report_mismatch("unexpected result, last", 32'(last_o), 32'h0);
        end else begin
          want = pieces_expected.pop_front();
          if (kind_o !== want.kind) report_mismatch("kind", 32'(kind_o), 32'(want.kind));
          if (r0_x_o !== want.v0[0]) report_mismatch("r0_x", r0_x_o, want.v0[0]);
          if (r0_y_o !== want.v0[1]) report_mismatch("r0_y", r0_y_o, want.v0[1]);
          if (r0_z_o !== want.v0[2]) report_mismatch("r0_z", r0_z_o, want.v0[2]);
          if (r1_x_o !== want.v1[0]) report_mismatch("r1_x", r1_x_o, want.v1[0]);
          if (r1_y_o !== want.v1[1]) report_mismatch("r1_y", r1_y_o, want.v1[1]);
          if (r1_z_o !== want.v1[2]) report_mismatch("r1_z", r1_z_o, want.v1[2]);
          if (r2_x_o !== want.v2[0]) report_mismatch("r2_x", r2_x_o, want.v2[0]);
          if (r2_y_o !== want.v2[1]) report_mismatch("r2_y", r2_y_o, want.v2[1]);
          if (r2_z_o !== want.v2[2]) report_mismatch("r2_z", r2_z_o, want.v2[2]);
          if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
      pop <= (hold_left == 0) && !(hold_request && !hold_done) &&
             ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** triangle_plane_splitter: FAILED **");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; the register takes it on the
  // edge that ends the access cycle.
  task automatic write_plane_reg(int index, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(4 * index);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      0: plane_nx   = longint'($signed(value[15:0]));
      1: plane_ny   = longint'($signed(value[15:0]));
      2: plane_nz   = longint'($signed(value[15:0]));
      3: plane_offs = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                           logic [31:0] offs);
    write_plane_reg(0, {16'h0, nx});
    write_plane_reg(1, {16'h0, ny});
    write_plane_reg(2, {16'h0, nz});
    write_plane_reg(3, offs);
  endtask

  // Mostly modest coordinates so splits are common; some use all 32 bits.
  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      2: return {{16{$urandom_range(1) == 1}}, 16'($urandom())};
      default: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
    endcase
  endfunction

  function automatic vec_t random_vertex();
    vec_t v;
    for (int j = 0; j < 3; j++) v[j] = random_coord();
    return v;
  endfunction

  // Vertex with a chosen y and random x and z, for the default plane y = 0.
  function automatic vec_t vertex_at_y(logic [31:0] y);
    vec_t v;
    v    = random_vertex();
    v[1] = y;
    return v;
  endfunction

  task automatic queue_triangle(vec_t a, vec_t b, vec_t c);
    tri_t t;
    t.a = a;
    t.b = b;
    t.c = c;
    @(negedge clk_i);
    triangles_pending.insert(triangles_pending.size(), t);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      queue_triangle(random_vertex(), random_vertex(), random_vertex());
    end
  endtask

  // Waits until every triangle is sent and every piece has come back.
  task automatic drain();
    while (triangles_pending.size() > 0 || pieces_expected.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    hold_request  = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 64;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    push          = 1'b0;
    pop           = 1'b0;
    drv_a         = '0;
    drv_b         = '0;
    drv_c         = '0;
    plane_nx      = 0;
    plane_ny      = 16384;
    plane_nz      = 0;
    plane_offs    = 0;
    @(posedge rst_ni);

    // Directed part against the reset plane y = 0.
    queue_triangle(vertex_at_y(32'h0001_0000), vertex_at_y(32'h0002_0000),
                   vertex_at_y(32'h7fff_ffff));
    queue_triangle(vertex_at_y(32'hffff_0000), vertex_at_y(32'h8000_0000),
                   vertex_at_y(32'hffff_ffff));
    // Each vertex in turn alone on the front side, then alone on the back side.
    queue_triangle(vertex_at_y(32'h0001_0000), vertex_at_y(32'hffff_0000),
                   vertex_at_y(32'hfffe_0000));
    queue_triangle(vertex_at_y(32'hffff_0000), vertex_at_y(32'h0003_0000),
                   vertex_at_y(32'hfffd_0000));
    queue_triangle(vertex_at_y(32'hffff_0000), vertex_at_y(32'hfff0_0000),
                   vertex_at_y(32'h0000_8000));
    queue_triangle(vertex_at_y(32'hffff_0000), vertex_at_y(32'h0001_0000),
                   vertex_at_y(32'h0002_0000));
    queue_triangle(vertex_at_y(32'h0004_0000), vertex_at_y(32'hffff_0000),
                   vertex_at_y(32'h0001_0000));
    queue_triangle(vertex_at_y(32'h0004_0000), vertex_at_y(32'h0001_0000),
                   vertex_at_y(32'hffff_ffff));
    // A vertex exactly on the plane counts as front.
    queue_triangle(vertex_at_y(32'h0000_0000), vertex_at_y(32'hffff_0000),
                   vertex_at_y(32'hfffe_0000));
    queue_triangle(vertex_at_y(32'h0000_0000), vertex_at_y(32'h0000_0000),
                   vertex_at_y(32'h0000_0000));
    // Extreme coordinates on every axis across the plane.
    queue_triangle({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                   {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                   {32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
    queue_triangle({32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff},
                   {32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000},
                   {32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff});
    drain();

    // Extreme plane: full negative x normal, extreme offset.
    set_plane(16'hc000, 16'h0000, 16'h0000, 32'h7fff_ffff);
    queue_triangle({32'h7fff_ffff, 32'h0, 32'h0}, {32'h8000_0000, 32'h0, 32'h0},
                   {32'h0, 32'h7fff_ffff, 32'h8000_0000});
    queue_random(6);
    drain();
    set_plane(16'h0000, 16'h0000, 16'h4000, 32'h8000_0000);
    queue_triangle({32'h0, 32'h0, 32'h8000_0000}, {32'h0, 32'h0, 32'h7fff_ffff},
                   {32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff});
    queue_random(6);
    drain();

    // Random part: oblique planes, including normals beyond one.
    set_plane(16'h2d41, 16'hd2bf, 16'h1000, 32'h0000_0000);
    queue_random(25);
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 38;
    set_plane(16'h7fff, 16'h8000, 16'h7fff, 32'hfff8_0000);
    queue_random(25);
    drain();

    // Receiver holds off while triangles keep coming, filling the block.
    send_idle_pct = 0;
    set_plane(16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom_range(32'h000f_ffff));
    @(negedge clk_i);
    hold_request = 1'b1;
    queue_random(20);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_plane(16'h0000, 16'h4000, 16'h0000, 32'h0000_0000);
    queue_random(25);
    drain();

    if (error_count == 0) begin
      $display("** triangle_plane_splitter: PASSED **");
    end else begin
      $display("** triangle_plane_splitter: FAILED **");
    end
    $finish;
  end

endmodule

@@ triangle_plane_splitter.f @@
hw/rtl/tps_pkg.sv
hw/rtl/tps_queue.sv
hw/rtl/tps_front.sv
hw/rtl/tps_back.sv
hw/rtl/triangle_plane_splitter.sv
tb/tb_triangle_plane_splitter.sv
